// ===== rtl/deq_pkg.sv =====
// shared types for the double-ended queue: operation and status codes,
// controller states and the controller-to-datapath command group
// no dependencies
package deq_pkg;

    // operation carried in the input word's tuser
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } op_t;

    // result status carried in the output word's tuser
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POST
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_in;   // capture the accepted input word
        logic exec;      // update pointers, write or read the ring
        logic load_out;  // move the finished result into the output register
    } cmd_t;

    localparam int unsigned WORD_W = 32;

endpackage

// ===== rtl/deq_ctrl.sv =====
// controller for the double-ended queue: sequences one operation at a time
// and owns the output handshake; depends on deq_pkg
module deq_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output deq_pkg::cmd_t cmd
);

    deq_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    // output register can take a new result
    assign out_free = !out_valid_reg || out_ready;

    // state and output-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= deq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            deq_pkg::S_IDLE: begin
                if (in_valid) state_next = deq_pkg::S_EXEC;
            end
            deq_pkg::S_EXEC: begin
                state_next = deq_pkg::S_POST;
            end
            deq_pkg::S_POST: begin
                if (out_free) state_next = deq_pkg::S_IDLE;
            end
            default: begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase
    end

    // commands and handshake outputs
    always_comb begin
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            deq_pkg::S_IDLE: begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            deq_pkg::S_EXEC: begin
                cmd.exec = 1'b1;
            end
            deq_pkg::S_POST: begin
                cmd.load_out = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // output word valid: set on load, cleared when taken
    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/deq_dpath.sv =====
// datapath for the double-ended queue: ring memory, head and count
// registers, wrap arithmetic and the output register; depends on deq_pkg
module deq_dpath #(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned IDX_W    = 4,
    parameter int unsigned CNT_W    = 5
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  deq_pkg::cmd_t              cmd,
    input  deq_pkg::op_t               op_in,
    input  logic [deq_pkg::WORD_W-1:0] value_in,
    output deq_pkg::status_t           status_out,
    output logic [deq_pkg::WORD_W-1:0] popped_out,
    output logic [CNT_W-1:0]           occupancy_out
);

    localparam int unsigned SUM_W = CNT_W + 1;

    // ring memory and registered read port
    logic [deq_pkg::WORD_W-1:0] ring_mem [CAPACITY];
    logic [deq_pkg::WORD_W-1:0] rd_data_reg;

    // captured input word
    deq_pkg::op_t               op_reg;
    logic [deq_pkg::WORD_W-1:0] value_reg;

    // queue pointers
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // per-operation staging
    deq_pkg::status_t status_reg, status_next;
    logic             pop_ok_reg, pop_ok_next;

    // output register
    deq_pkg::status_t           out_status_reg;
    logic [deq_pkg::WORD_W-1:0] out_popped_reg;
    logic [CNT_W-1:0]           out_occ_reg;

    // address arithmetic
    logic             full, empty;
    logic [IDX_W-1:0] head_dec, head_inc, tail_slot, last_slot;
    logic [SUM_W-1:0] tail_sum, last_sum;
    logic             mem_we;
    logic [IDX_W-1:0] waddr, raddr;

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);

    // one step back and forward around the ring
    assign head_dec = (head_reg == '0) ? IDX_W'(CAPACITY - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == IDX_W'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;

    // slot after the rear element and the rear element itself
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign last_sum  = tail_sum - 1'b1;
    assign tail_slot = (tail_sum >= SUM_W'(CAPACITY))
                     ? IDX_W'(tail_sum - SUM_W'(CAPACITY)) : IDX_W'(tail_sum);
    assign last_slot = (last_sum >= SUM_W'(CAPACITY))
                     ? IDX_W'(last_sum - SUM_W'(CAPACITY)) : IDX_W'(last_sum);

    // operation decode
    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = status_reg;
        pop_ok_next = pop_ok_reg;
        mem_we      = 1'b0;
        waddr       = head_dec;
        raddr       = head_reg;
        if (cmd.exec) begin
            status_next = deq_pkg::ST_DONE;
            pop_ok_next = 1'b0;
            case (op_reg)
                deq_pkg::OP_PUSH_FRONT: begin
                    if (full) begin
                        status_next = deq_pkg::ST_OVERFLOW;
                    end else begin
                        mem_we     = 1'b1;
                        waddr      = head_dec;
                        head_next  = head_dec;
                        count_next = count_reg + 1'b1;
                    end
                end
                deq_pkg::OP_PUSH_REAR: begin
                    if (full) begin
                        status_next = deq_pkg::ST_OVERFLOW;
                    end else begin
                        mem_we     = 1'b1;
                        waddr      = tail_slot;
                        count_next = count_reg + 1'b1;
                    end
                end
                deq_pkg::OP_POP_FRONT: begin
                    if (empty) begin
                        status_next = deq_pkg::ST_UNDERFLOW;
                    end else begin
                        raddr       = head_reg;
                        pop_ok_next = 1'b1;
                        head_next   = head_inc;
                        count_next  = count_reg - 1'b1;
                    end
                end
                deq_pkg::OP_POP_REAR: begin
                    if (empty) begin
                        status_next = deq_pkg::ST_UNDERFLOW;
                    end else begin
                        raddr       = last_slot;
                        pop_ok_next = 1'b1;
                        count_next  = count_reg - 1'b1;
                    end
                end
                default: begin
                    status_next = deq_pkg::ST_DONE;
                end
            endcase
        end
    end

    // pointer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // ring memory: one write port, one registered read port held until the next access
    always_ff @(posedge aclk) begin
        if (mem_we) ring_mem[waddr] <= value_reg;
        if (cmd.exec) rd_data_reg <= ring_mem[raddr];
    end

    // input capture, staging and output register
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg    <= op_in;
            value_reg <= value_in;
        end
        status_reg <= status_next;
        pop_ok_reg <= pop_ok_next;
        if (cmd.load_out) begin
            out_status_reg <= status_reg;
            out_popped_reg <= pop_ok_reg ? rd_data_reg : '0;
            out_occ_reg    <= count_reg;
        end
    end

    assign status_out    = out_status_reg;
    assign popped_out    = out_popped_reg;
    assign occupancy_out = out_occ_reg;

endmodule

// ===== rtl/double_ended_queue.sv =====
// top level of the bounded double-ended queue of signed 32-bit words
// instantiates deq_ctrl and deq_dpath; uses deq_pkg
//
//  channel   direction  tdata                                tuser
//  s_axis    in         value[31:0]                          op[1:0]
//  m_axis    out        popped[31:0], occupancy above it     status[1:0]
//
// each operation goes through capture, one ring memory access with
// registered read data, then the output load; one operation is in flight at a time.
// a new word is accepted as soon as the previous one has been loaded, even
// while that result still waits in the output register.
// reset clears head, count and the handshake; ring contents start unknown.
// a stalled output holds the controller in its last step until taken.
module double_ended_queue #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [31:0]               s_axis_tdata,   // value[31:0]
    input  logic [1:0]                s_axis_tuser,   // op[1:0]
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // popped[31:0], occupancy[32 +: OCC_W], zero fill
    output logic [((32 + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic [1:0]                m_axis_tuser    // status[1:0]
);

    localparam int unsigned IDX_W     = $clog2(CAPACITY);
    localparam int unsigned OCC_W     = $clog2(CAPACITY + 1);
    localparam int unsigned M_TDATA_W = ((32 + OCC_W + 7) / 8) * 8;

    deq_pkg::cmd_t              cmd;
    deq_pkg::status_t           status;
    logic [deq_pkg::WORD_W-1:0] popped;
    logic [OCC_W-1:0]           occupancy;

    // operation sequencing and output handshake
    deq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    // ring memory and pointers
    deq_dpath #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (OCC_W)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .op_in         (deq_pkg::op_t'(s_axis_tuser)),
        .value_in      (s_axis_tdata),
        .status_out    (status),
        .popped_out    (popped),
        .occupancy_out (occupancy)
    );

    // pack the result word
    assign m_axis_tdata = M_TDATA_W'({occupancy, popped});
    assign m_axis_tuser = status;

`ifndef SYNTH
    // one operation in flight: no acceptance right after an acceptance
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second word accepted while an operation is running");

    // occupancy never exceeds the capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[32 +: OCC_W] <= OCC_W'(CAPACITY)))
        else $error("occupancy above capacity");

    // underflow only on an empty queue and with no popped word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == deq_pkg::ST_UNDERFLOW)
            |-> (m_axis_tdata[32 +: OCC_W] == '0 && m_axis_tdata[31:0] == '0))
        else $error("underflow reported on a non-empty queue");

    // overflow only on a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == deq_pkg::ST_OVERFLOW)
            |-> (m_axis_tdata[32 +: OCC_W] == OCC_W'(CAPACITY)))
        else $error("overflow reported on a queue that is not full");
`endif

endmodule
